// ===== rtl/core/kcl_pkg.sv =====
package kcl_pkg;

	// default number of cells in one code bank
	localparam int MAX_CODE_LENGTH = 128;

	// key codes
	localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [3:0] KEY_HASH      = 4'd11;
	localparam logic [3:0] KEY_R         = 4'd12;
	localparam logic [3:0] KEY_O         = 4'd13;
	localparam logic [3:0] KEY_K         = 4'd14;

	// input item kinds
	localparam logic KIND_KEY     = 1'b0;
	localparam logic KIND_TIMEOUT = 1'b1;

	// event results
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_ACCEPT  = 2'd1;
	localparam logic [1:0] EV_REJECT  = 2'd2;
	localparam logic [1:0] EV_CHANGED = 2'd3;

	// door commands
	localparam logic [1:0] DOOR_NONE = 2'd0;
	localparam logic [1:0] DOOR_AUTO = 2'd1;
	localparam logic [1:0] DOOR_HOLD = 2'd2;

	// store access strobes from the controller
	typedef struct packed {
		logic rd;
		logic wr;
	} mem_ctl_t;

endpackage

// ===== rtl/core/kcl_store.sv =====
module kcl_store #(
	parameter int MAX_LEN = kcl_pkg::MAX_CODE_LENGTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kcl_pkg::mem_ctl_t                mem_ctl,
	input  logic [$clog2(2*MAX_LEN)-1:0]     addr,
	input  logic [3:0]                       wdata,
	output logic [3:0]                       rdata,
	output logic                             busy
);
	import kcl_pkg::*;

	localparam int DEPTH = 2 * MAX_LEN;
	localparam int AW    = $clog2(DEPTH);

	logic [3:0]    mem [DEPTH];
	logic [AW-1:0] clr_q;
	logic          clr_busy_q;
	logic [3:0]    rdata_q;

	// clearing pass after reset: every cell gets the hash terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			if (clr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	// single port cell array, registered read
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_q] <= KEY_HASH;
		end else if (mem_ctl.wr) begin
			mem[addr] <= wdata;
		end
		if (mem_ctl.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = clr_busy_q;

endmodule

// ===== rtl/core/kcl_ctrl.sv =====
module kcl_ctrl #(
	parameter int MAX_LEN = kcl_pkg::MAX_CODE_LENGTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// key event stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [3:0]                       key_code,
	input  logic                             kind,
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [1:0]                       event_res,
	output logic [1:0]                       door_command,
	output logic [1:0]                       beep_length,
	output logic [1:0]                       beep_count,
	output logic                             in_change_mode,
	// code store
	output kcl_pkg::mem_ctl_t                mem_ctl,
	output logic [$clog2(2*MAX_LEN)-1:0]     addr,
	output logic [3:0]                       wdata,
	input  logic [3:0]                       rdata,
	input  logic                             busy
);
	import kcl_pkg::*;

	localparam int AW = $clog2(2 * MAX_LEN);
	localparam int PW = $clog2(MAX_LEN);

	logic [PW-1:0] pos_q;
	logic          mode_q;
	logic          bank_q;

	logic          valid_s1;
	logic [3:0]    key_s1;
	logic          kind_s1;

	logic          out_valid_q;
	logic [1:0]    ev_q, door_q, blen_q, bcnt_q;
	logic          mode_out_q;

	logic          accept, do_s1;
	logic [AW-1:0] act_addr, stg_addr;
	logic [PW-1:0] nxt_pos;
	logic          nxt_mode, nxt_bank, wr_cell;
	logic [3:0]    wr_val;
	logic [1:0]    ev_d, door_d, blen_d, bcnt_d;
	logic [PW-1:0] pos_inc;
	logic          room;

	// one event in flight: store read on transfer, evaluate once the output register is free
	assign s_tready = !busy && !valid_s1;
	assign accept   = s_tvalid && s_tready;
	assign do_s1    = valid_s1 && (!out_valid_q || m_tready);

	// cell addresses of the current position in either bank
	assign act_addr = bank_q  ? (AW'(MAX_LEN) + AW'(pos_q)) : AW'(pos_q);
	assign stg_addr = !bank_q ? (AW'(MAX_LEN) + AW'(pos_q)) : AW'(pos_q);

	assign pos_inc = pos_q + 1'b1;
	assign room    = {1'b0, pos_q} < (PW + 1)'(MAX_LEN - 1);

	// key evaluation against the read cell
	always_comb begin
		nxt_pos  = pos_q;
		nxt_mode = mode_q;
		nxt_bank = bank_q;
		wr_cell  = 1'b0;
		wr_val   = key_s1;
		ev_d     = EV_NONE;
		door_d   = DOOR_NONE;
		blen_d   = 2'd0;
		bcnt_d   = 2'd0;
		priority if (kind_s1 == KIND_TIMEOUT) begin
			nxt_pos  = '0;
			nxt_mode = 1'b0;
		end else if (key_s1 <= KEY_DIGIT_MAX) begin
			blen_d = 2'd1;
			bcnt_d = 2'd1;
			if (mode_q) begin
				if (room) begin
					wr_cell = 1'b1;
					nxt_pos = pos_inc;
				end
			end else if (rdata == key_s1) begin
				nxt_pos = pos_inc;
			end else begin
				nxt_pos = '0;
			end
		end else if (key_s1 == KEY_HASH) begin
			nxt_pos = '0;
			blen_d  = 2'd1;
			if (mode_q) begin
				bcnt_d   = 2'd1;
				wr_cell  = 1'b1;
				wr_val   = KEY_HASH;
				nxt_bank = !bank_q;
				nxt_mode = 1'b0;
				ev_d     = EV_CHANGED;
			end else if (rdata == KEY_HASH) begin
				bcnt_d = 2'd1;
				ev_d   = EV_ACCEPT;
				door_d = DOOR_AUTO;
			end else begin
				bcnt_d = 2'd3;
				ev_d   = EV_REJECT;
			end
		end else if (key_s1 == KEY_R) begin
			blen_d   = 2'd3;
			bcnt_d   = 2'd1;
			nxt_mode = 1'b1;
			nxt_pos  = '0;
		end else if (key_s1 == KEY_O) begin
			blen_d  = 2'd1;
			bcnt_d  = 2'd1;
			door_d  = DOOR_AUTO;
			nxt_pos = '0;
		end else if (key_s1 == KEY_K) begin
			blen_d  = 2'd3;
			bcnt_d  = 2'd1;
			door_d  = DOOR_HOLD;
			nxt_pos = '0;
		end else begin
			// star and B keys do nothing
			nxt_pos = pos_q;
		end
	end

	// store port: read at transfer, write back while evaluating
	assign mem_ctl.rd = accept;
	assign mem_ctl.wr = do_s1 && wr_cell;
	assign addr       = valid_s1 ? stg_addr : act_addr;
	assign wdata      = wr_val;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (do_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1  <= key_code;
			kind_s1 <= kind;
		end
	end

	// lock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			mode_q <= 1'b0;
			bank_q <= 1'b0;
		end else if (do_s1) begin
			pos_q  <= nxt_pos;
			mode_q <= nxt_mode;
			bank_q <= nxt_bank;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_s1) begin
			ev_q       <= ev_d;
			door_q     <= door_d;
			blen_q     <= blen_d;
			bcnt_q     <= bcnt_d;
			mode_out_q <= nxt_mode;
		end
	end

	assign m_tvalid       = out_valid_q;
	assign event_res      = ev_q;
	assign door_command   = door_q;
	assign beep_length    = blen_q;
	assign beep_count     = bcnt_q;
	assign in_change_mode = mode_out_q;

endmodule

// ===== rtl/core/keypad_combination_lock.sv =====
// Keypad combination lock core. Each transfer on the s_ side is one key
// press or one inactivity timeout, and it yields exactly one result transfer
// on the m_ side. The transfer cycle reads the current cell of the code
// store; evaluation then checks the key, writes the staging bank back when a
// new code is entered and loads the result register, waiting while an earlier
// result stalls on m_tready. s_tready returns the cycle after evaluation, so
// a new event is taken only once the last one is evaluated, while a finished
// result may still wait on m_tready. After reset the store runs a clearing
// pass over the 2 * MAX_CODE_LENGTH cells (256 at default) that fills every
// cell with the hash terminator; s_tready stays low until it completes.
module keypad_combination_lock #(
	parameter int MAX_CODE_LENGTH = kcl_pkg::MAX_CODE_LENGTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [3:0] key_code, [7:4] zero
	input  logic [0:0]  s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [1:0] event_res, [3:2] door_command,
	                               // [5:4] beep_length, [7:6] beep_count,
	                               // [8] in_change_mode, [15:9] zero
);
	import kcl_pkg::*;

	localparam int AW = $clog2(2 * MAX_CODE_LENGTH);

	mem_ctl_t      mem_ctl;
	logic [AW-1:0] addr;
	logic [3:0]    wdata, rdata;
	logic          busy;
	logic [1:0]    event_res, door_command, beep_length, beep_count;
	logic          in_change_mode;

	kcl_store #(
		.MAX_LEN(MAX_CODE_LENGTH)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.mem_ctl(mem_ctl),
		.addr   (addr),
		.wdata  (wdata),
		.rdata  (rdata),
		.busy   (busy)
	);

	kcl_ctrl #(
		.MAX_LEN(MAX_CODE_LENGTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.key_code      (s_tdata[3:0]),
		.kind          (s_tuser[0]),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.event_res     (event_res),
		.door_command  (door_command),
		.beep_length   (beep_length),
		.beep_count    (beep_count),
		.in_change_mode(in_change_mode),
		.mem_ctl       (mem_ctl),
		.addr          (addr),
		.wdata         (wdata),
		.rdata         (rdata),
		.busy          (busy)
	);

	assign m_tdata = {7'd0, in_change_mode, beep_count, beep_length, door_command, event_res};

endmodule

// ===== rtl/core/kcl_checker.sv =====
module kcl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	import kcl_pkg::*;

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// at most one event in flight: no transfer right after a transfer
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an event is in flight");

	// an accepted code always opens the door with auto close
	a_accept_door: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == EV_ACCEPT |-> m_tdata[3:2] == DOOR_AUTO)
		else $error("accept without door open");

	// a completed code change leaves change mode
	a_change_exit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == EV_CHANGED |-> !m_tdata[8])
		else $error("code change did not leave change mode");

	// no beep count without a beep length, and padding stays zero
	a_beep_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[5:4] != 2'd0 || m_tdata[7:6] == 2'd0) && m_tdata[15:9] == 7'd0)
		else $error("malformed result word");

endmodule

bind keypad_combination_lock kcl_checker u_kcl_checker (.*);
